FILE: rtl/sha256_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BLOCK_W = 512;
  localparam int unsigned FILL_W  = 6;
  localparam int unsigned ROUND_W = 6;
  localparam int unsigned LEN_W   = 64;
  localparam int unsigned LENCNT_W = 4;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
  localparam logic [FILL_W-1:0] FILL_LEN  = 6'd56;
  localparam logic [LENCNT_W-1:0] LEN_BYTES = 4'd8;
  localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST = 3'd7;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic push;
    logic load;
    logic round;
    logic update;
    logic init;
  } ctrl_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sha256_sched.sv
`timescale 1ns / 1ps
`default_nettype none

module sha256_sched (
  input  wire logic              clk,
  input  wire sha256_pkg::ctrl_t ctrl,
  input  wire logic [7:0]        push_data,
  output logic [31:0]            w
);
  import sha256_pkg::*;

  logic [BLOCK_W-1:0] blk;
  logic [WORD_W-1:0]  w1;
  logic [WORD_W-1:0]  w9;
  logic [WORD_W-1:0]  w14;
  logic [WORD_W-1:0]  s0;
  logic [WORD_W-1:0]  s1;
  logic [WORD_W-1:0]  w_new;

  // window holds w[j] .. w[j+15], w[j] in the top word
  assign w   = blk[511:480];
  assign w1  = blk[479:448];
  assign w9  = blk[223:192];
  assign w14 = blk[63:32];

  always_comb begin
    s0    = ror32(w1, 7) ^ ror32(w1, 18) ^ (w1 >> 3);
    s1    = ror32(w14, 17) ^ ror32(w14, 19) ^ (w14 >> 10);
    w_new = w + s0 + w9 + s1;
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      blk <= {blk[BLOCK_W-9:0], push_data};
    end else if (ctrl.round) begin
      blk <= {blk[BLOCK_W-WORD_W-1:0], w_new};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sha256_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sha256_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sha256_pkg::ctrl_t ctrl,
  input  wire logic [5:0]        round_idx,
  input  wire logic [31:0]       w,
  input  wire logic [2:0]        word_sel,
  output logic [31:0]            hash_word
);
  import sha256_pkg::*;

  logic [WORD_W-1:0] hash [8];
  logic [WORD_W-1:0] v [8];
  logic [WORD_W-1:0] v_next [8];
  logic [WORD_W-1:0] big0;
  logic [WORD_W-1:0] big1;
  logic [WORD_W-1:0] mj;
  logic [WORD_W-1:0] chs;
  logic [WORD_W-1:0] x1;
  logic [WORD_W-1:0] x2;

  always_comb begin
    big0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
    mj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    big1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
    chs  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    x1   = v[7] + big1 + chs + K[round_idx] + w;
    x2   = big0 + mj;
    v_next[0] = x1 + x2;
    v_next[1] = v[0];
    v_next[2] = v[1];
    v_next[3] = v[2];
    v_next[4] = v[3] + x1;
    v_next[5] = v[4];
    v_next[6] = v[5];
    v_next[7] = v[6];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      v <= hash;
    end else if (ctrl.round) begin
      v <= v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.init) begin
      hash <= IV;
    end else if (ctrl.update) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= hash[i] + v[i];
      end
    end
  end

  assign hash_word = hash[word_sel];

endmodule

`default_nettype wire

FILE: rtl/sha256_stream_hasher.sv
`timescale 1ns / 1ps
`default_nettype none
// each input byte is taken in ST_IDLE; the 64th byte of a block starts the
// shared round unit (ST_ROUND), then the hash update (ST_UPDATE)
// last byte: padding bytes up to the block end, each block through ST_ROUND and
// ST_UPDATE, then eight digest transfers, one per cycle while m_axis_tready is high
// rst (synchronous) loads the initial hash and clears length and fill; the same
// happens after the eighth digest transfer

module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tlast,   // last_byte
  input  wire logic        s_axis_tuser,   // empty_message
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // digest_word, word_index, zero fill
  output logic             m_axis_tlast    // digest_last
);
  import sha256_pkg::*;

  state_t state;
  state_t state_next;
  ctrl_t  ctrl;

  logic [FILL_W-1:0]   fill;
  logic [LEN_W-1:0]    message_bits;
  logic [LENCNT_W-1:0] len_cnt;
  logic [ROUND_W-1:0]  round_cnt;
  logic [2:0]          out_idx;
  logic                sent80;
  logic                finishing;

  logic       in_xfer;
  logic       out_xfer;
  logic       done;
  logic       block_full;
  logic       len_push;
  logic [7:0] pad_byte;
  logic [7:0] push_data;
  logic [WORD_W-1:0] w;
  logic [WORD_W-1:0] hash_word;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign done     = out_xfer && (out_idx == WORD_LAST);

  always_comb begin
    len_push = (state == ST_PAD) && sent80 && ((len_cnt != '0) || (fill == FILL_LEN));
    if (!sent80) begin
      pad_byte = PAD_BYTE;
    end else if (len_push) begin
      pad_byte = message_bits[LEN_W-1 -: 8];
    end else begin
      pad_byte = 8'h00;
    end
    push_data  = (state == ST_PAD) ? pad_byte : s_axis_tdata;
    block_full = ctrl.push && (fill == FILL_LAST);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (block_full) begin
            state_next = ST_ROUND;
          end else if (s_axis_tlast) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (block_full) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_cnt == ROUND_LAST) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!finishing) begin
          state_next = ST_IDLE;
        end else if (len_cnt == LEN_BYTES) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_OUT: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    m_axis_tvalid = (state == ST_OUT);
    ctrl.push     = (state == ST_PAD) ||
                    ((state == ST_IDLE) && s_axis_tvalid && !s_axis_tuser);
    ctrl.load     = ctrl.push && (fill == FILL_LAST);
    ctrl.round    = (state == ST_ROUND);
    ctrl.update   = (state == ST_UPDATE);
    ctrl.init     = (state == ST_OUT) && m_axis_tready && (out_idx == WORD_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      message_bits <= '0;
      len_cnt      <= '0;
      round_cnt    <= '0;
      out_idx      <= '0;
      sent80       <= 1'b0;
      finishing    <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.push) begin
        fill <= fill + 1'b1;
      end
      // length shifts out msb first; it is back to zero after the last length byte
      if (in_xfer && !s_axis_tuser) begin
        message_bits <= message_bits + LEN_W'(8);
      end else if (len_push) begin
        message_bits <= {message_bits[LEN_W-9:0], 8'h00};
      end
      if (done) begin
        len_cnt <= '0;
      end else if (len_push) begin
        len_cnt <= len_cnt + 1'b1;
      end
      if (ctrl.round) begin
        round_cnt <= round_cnt + 1'b1;
      end
      if (out_xfer) begin
        out_idx <= out_idx + 1'b1;
      end
      if (done) begin
        sent80 <= 1'b0;
      end else if (state == ST_PAD) begin
        sent80 <= 1'b1;
      end
      if (done) begin
        finishing <= 1'b0;
      end else if (in_xfer) begin
        finishing <= s_axis_tlast;
      end
    end
  end

  sha256_sched u_sched (
    .clk       (clk),
    .ctrl      (ctrl),
    .push_data (push_data),
    .w         (w)
  );

  sha256_core u_core (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .round_idx (round_cnt),
    .w         (w),
    .word_sel  (out_idx),
    .hash_word (hash_word)
  );

  assign m_axis_tdata = {5'b0, out_idx, hash_word};
  assign m_axis_tlast = (out_idx == WORD_LAST);

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } byte_item_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam int LEN_OFFSET = 56;
  localparam int BLOCK_BYTES = 64;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  sha256_stream_hasher dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  byte_item_t  byte_q[$];
  digest_t     digest_q[$];
  byte_item_t  on_wire;

  logic [31:0] hash_words [8];
  logic [31:0] blk_words [16];
  int          blk_fill;
  logic [63:0] msg_bits;

  int errors = 0;
  int items_sent = 0;
  int words_checked = 0;
  int msgs_queued = 0;
  int max_len = 0;
  int hold_cnt = 0;
  bit hold_done = 0;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic clear_hash();
    for (int i = 0; i < 8; i++) hash_words[i] = HASH_INIT[i];
    for (int i = 0; i < 16; i++) blk_words[i] = '0;
    blk_fill = 0;
    msg_bits = '0;
  endtask

  task automatic mix_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2, ch, maj;
    for (int j = 0; j < 16; j++) w[j] = blk_words[j];
    for (int j = 16; j < 64; j++) begin
      s0 = rotr(w[j-15], 7) ^ rotr(w[j-15], 18) ^ (w[j-15] >> 3);
      s1 = rotr(w[j-2], 17) ^ rotr(w[j-2], 19) ^ (w[j-2] >> 10);
      w[j] = w[j-16] + s0 + w[j-7] + s1;
    end
    for (int j = 0; j < 8; j++) v[j] = hash_words[j];
    for (int j = 0; j < 64; j++) begin
      s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1  = v[7] + s1 + ch + ROUND_K[j] + w[j];
      s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2  = s0 + maj;
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_words[j] = hash_words[j] + v[j];
  endtask

  task automatic put_block_byte(input logic [7:0] b);
    blk_words[blk_fill / 4][(3 - blk_fill % 4) * 8 +: 8] = b;
    blk_fill++;
    if (blk_fill == BLOCK_BYTES) begin
      mix_block();
      blk_fill = 0;
    end
  endtask

  // advance the hash by one accepted input transfer
  task automatic absorb_item(input byte_item_t it);
    logic [63:0] len;
    digest_t d;
    if (!it.empty) begin
      put_block_byte(it.data);
      msg_bits = msg_bits + 64'd8;
    end
    if (it.last) begin
      len = msg_bits;
      put_block_byte(PAD_MARK);
      while (blk_fill != LEN_OFFSET) put_block_byte(8'h00);
      for (int k = 0; k < 8; k++) put_block_byte(len[(7 - k) * 8 +: 8]);
      for (int k = 0; k < 8; k++) begin
        d.word  = hash_words[k];
        d.index = 3'(k);
        d.last  = (k == 7);
        digest_q.push_back(d);
      end
      clear_hash();
    end
  endtask

  task automatic push_item(input logic [7:0] data, input logic last, input logic empty);
    byte_item_t it;
    it.data  = data;
    it.last  = last;
    it.empty = empty;
    byte_q.push_back(it);
  endtask

  // random message of len bytes, with optional idle empty transfers mixed in
  task automatic queue_message(input int len, input bit tail_empty, input int noise_pct,
                               inout int counted);
    bit close_empty;
    close_empty = tail_empty || (len == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        push_item(8'($urandom), 1'b0, 1'b1);
      push_item(8'($urandom), (i == len - 1) && !close_empty, 1'b0);
      counted++;
    end
    if (close_empty) begin
      push_item(8'($urandom), 1'b1, 1'b1);
      counted++;
    end
    msgs_queued++;
    if (len > max_len) max_len = len;
  endtask

  wire calm_tx = (items_sent >= 60) && (items_sent < 110);
  wire calm_rx = (words_checked >= 24) && (words_checked < 64);

  always @(posedge clk) begin
    byte_item_t nxt;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_item(on_wire);
        items_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (byte_q.size() != 0 && (calm_tx || $urandom_range(0, 99) >= 32)) begin
          nxt = byte_q.pop_front();
          on_wire       <= nxt;
          s_axis_tdata  <= nxt.data;
          s_axis_tlast  <= nxt.last;
          s_axis_tuser  <= nxt.empty;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off while the next message is waiting
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && m_axis_tvalid && words_checked >= 16) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm_rx || ($urandom_range(0, 99) >= 32);
    end
  end

  always @(posedge clk) begin
    digest_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected digest transfer: expected none got %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = digest_q.pop_front();
        if (m_axis_tdata[31:0] !== want.word) begin
          errors++;
          $display("%0t: digest_word mismatch: expected %h got %h",
                   $time, want.word, m_axis_tdata[31:0]);
        end
        if (m_axis_tdata[34:32] !== want.index) begin
          errors++;
          $display("%0t: word_index mismatch: expected %0d got %0d",
                   $time, want.index, m_axis_tdata[34:32]);
        end
        if (m_axis_tlast !== want.last) begin
          errors++;
          $display("%0t: digest_last mismatch: expected %b got %b",
                   $time, want.last, m_axis_tlast);
        end
        words_checked++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int rand_items;
    int pick;
    int len;
    int wait_cnt;
    clear_hash();
    rand_items = 0;

    // empty message
    push_item(8'hff, 1'b1, 1'b1);
    // single byte extremes
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hff, 1'b1, 1'b0);
    // "abc"
    push_item(8'h61, 1'b0, 1'b0);
    push_item(8'h62, 1'b0, 1'b0);
    push_item(8'h63, 1'b1, 1'b0);
    // empty transfers inside a message and one closing it
    push_item(8'ha5, 1'b0, 1'b0);
    push_item(8'hff, 1'b0, 1'b1);
    push_item(8'h5a, 1'b0, 1'b0);
    push_item(8'h00, 1'b1, 1'b1);
    // idle empty transfer before an empty message
    push_item(8'h3c, 1'b0, 1'b1);
    push_item(8'hc3, 1'b1, 1'b1);
    msgs_queued = 6;
    max_len = 3;

    // stop short of the item budget, the last message runs past it
    while (byte_q.size() < 130) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) len = 0;
      else if (pick < 30) len = $urandom_range(52, 68);
      else len = $urandom_range(1, 20);
      queue_message(len, $urandom_range(0, 3) == 0, 10, rand_items);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (byte_q.size() != 0 || s_axis_tvalid);
    wait_cnt = 0;
    while (digest_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (200) @(posedge clk);

    $display("hashed %0d messages (longest %0d bytes) from %0d input transfers",
             msgs_queued, max_len, items_sent);
    $display("checked %0d digest words, %0d still outstanding", words_checked,
             digest_q.size());
    if (errors == 0 && digest_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/sha256_pkg.sv
rtl/sha256_sched.sv
rtl/sha256_core.sv
rtl/sha256_stream_hasher.sv
sim/tb.sv
